### rtl/core/sbcc_pkg.sv
package sbcc_pkg;

  localparam int POS_W      = 24;
  localparam int SCL_W      = 16;
  localparam int MUL_W      = 24;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int HALF_W     = POS_W + SCL_W;
  localparam int HALF_SPLIT = HALF_W / 2;
  localparam int DMAG_W     = POS_W + 2;
  localparam int DD_W       = DMAG_W + 1;
  localparam int FRAC_SH    = 8;
  localparam int CMP_W      = HALF_W + 1;
  localparam int ACC_W      = 2 * HALF_W;
  localparam int SH_HH      = 2 * HALF_SPLIT;
  localparam int SH_HL      = HALF_SPLIT + 1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_TEST   = 1'b1;
  localparam logic SHP_RECT  = 1'b0;
  localparam logic SHP_ROUND = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BB   = 2'd1,
    KIND_BC   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_BX,
    ST_MUL_BY,
    ST_MUL_OX,
    ST_MUL_OY,
    ST_BB_X,
    ST_BB_Y,
    ST_GAP_X,
    ST_GAP_Y,
    ST_SQ,
    ST_SQ_END,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MOP_BX,
    MOP_BY,
    MOP_OX,
    MOP_OY,
    MOP_SQ
  } mop_t;

  typedef enum logic [1:0] {
    SQ_RAD,
    SQ_GAPX,
    SQ_GAPY
  } sq_sel_t;

  typedef enum logic [1:0] {
    PART_HH,
    PART_HL,
    PART_LL
  } sq_part_t;

  typedef struct packed {
    logic     busy;
    mop_t     mop;
    logic     wr_hx;
    logic     wr_hy;
    logic     wr_ox;
    logic     wr_oy;
    logic     bb_x;
    logic     bb_y;
    logic     gap_x;
    logic     gap_y;
    logic     sq_issue;
    sq_sel_t  sq_sel;
    sq_part_t sq_part;
    logic     done_ld;
  } ctl_t;

endpackage

### rtl/core/sbcc_in_if.sv
interface sbcc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic                              shape;
  logic signed [sbcc_pkg::POS_W-1:0] pos_x;
  logic signed [sbcc_pkg::POS_W-1:0] pos_y;
  logic signed [sbcc_pkg::POS_W-1:0] offset_x;
  logic signed [sbcc_pkg::POS_W-1:0] offset_y;
  logic signed [sbcc_pkg::POS_W-1:0] coll_width;
  logic signed [sbcc_pkg::POS_W-1:0] coll_height;
  logic signed [sbcc_pkg::SCL_W-1:0] scale_x;
  logic signed [sbcc_pkg::SCL_W-1:0] scale_y;

  modport source (
    output valid, opcode, shape, pos_x, pos_y, offset_x, offset_y,
           coll_width, coll_height, scale_x, scale_y,
    input  ready
  );

  modport sink (
    input  valid, opcode, shape, pos_x, pos_y, offset_x, offset_y,
           coll_width, coll_height, scale_x, scale_y,
    output ready
  );
endinterface

### rtl/core/sbcc_out_if.sv
interface sbcc_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] test_kind;

  modport source (
    output valid, hit, test_kind,
    input  ready
  );

  modport sink (
    input  valid, hit, test_kind,
    output ready
  );
endinterface

### rtl/core/sbcc_mul.sv
module sbcc_mul (
  input  logic                         clk,
  input  logic [sbcc_pkg::MUL_W-1:0]   a,
  input  logic [sbcc_pkg::MUL_W-1:0]   b,
  output logic [sbcc_pkg::PROD_W-1:0]  p
);

  logic [sbcc_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= sbcc_pkg::PROD_W'(a) * sbcc_pkg::PROD_W'(b);
  end

  assign p = p_r;

endmodule

### rtl/core/sbcc_seq.sv
module sbcc_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  sbcc_pkg::kind_t kind,
  input  logic            out_free,
  output sbcc_pkg::ctl_t  ctl
);

  sbcc_pkg::state_t   state_r, state_nxt;
  sbcc_pkg::sq_sel_t  sq_sel_r, sq_sel_nxt;
  sbcc_pkg::sq_part_t sq_part_r, sq_part_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sbcc_pkg::ST_IDLE;
      sq_sel_r  <= sbcc_pkg::SQ_RAD;
      sq_part_r <= sbcc_pkg::PART_HH;
    end else begin
      state_r   <= state_nxt;
      sq_sel_r  <= sq_sel_nxt;
      sq_part_r <= sq_part_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sq_sel_nxt  = sq_sel_r;
    sq_part_nxt = sq_part_r;
    case (state_r)
      sbcc_pkg::ST_IDLE: begin
        if (start) state_nxt = sbcc_pkg::ST_MUL_BX;
      end
      sbcc_pkg::ST_MUL_BX: begin
        state_nxt = (kind == sbcc_pkg::KIND_NONE) ? sbcc_pkg::ST_DONE : sbcc_pkg::ST_MUL_BY;
      end
      sbcc_pkg::ST_MUL_BY: state_nxt = sbcc_pkg::ST_MUL_OX;
      sbcc_pkg::ST_MUL_OX: begin
        state_nxt = (kind == sbcc_pkg::KIND_BB) ? sbcc_pkg::ST_MUL_OY : sbcc_pkg::ST_GAP_X;
      end
      sbcc_pkg::ST_MUL_OY: state_nxt = sbcc_pkg::ST_BB_X;
      sbcc_pkg::ST_BB_X:   state_nxt = sbcc_pkg::ST_BB_Y;
      sbcc_pkg::ST_BB_Y:   state_nxt = sbcc_pkg::ST_DONE;
      sbcc_pkg::ST_GAP_X:  state_nxt = sbcc_pkg::ST_GAP_Y;
      sbcc_pkg::ST_GAP_Y: begin
        state_nxt   = sbcc_pkg::ST_SQ;
        sq_sel_nxt  = sbcc_pkg::SQ_RAD;
        sq_part_nxt = sbcc_pkg::PART_HH;
      end
      sbcc_pkg::ST_SQ: begin
        case (sq_part_r)
          sbcc_pkg::PART_HH: sq_part_nxt = sbcc_pkg::PART_HL;
          sbcc_pkg::PART_HL: sq_part_nxt = sbcc_pkg::PART_LL;
          default: begin
            sq_part_nxt = sbcc_pkg::PART_HH;
            case (sq_sel_r)
              sbcc_pkg::SQ_RAD:  sq_sel_nxt = sbcc_pkg::SQ_GAPX;
              sbcc_pkg::SQ_GAPX: sq_sel_nxt = sbcc_pkg::SQ_GAPY;
              default:           state_nxt  = sbcc_pkg::ST_SQ_END;
            endcase
          end
        endcase
      end
      sbcc_pkg::ST_SQ_END: state_nxt = sbcc_pkg::ST_DONE;
      sbcc_pkg::ST_DONE: begin
        if (out_free) state_nxt = sbcc_pkg::ST_IDLE;
      end
      default: state_nxt = sbcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.mop     = sbcc_pkg::MOP_BX;
    ctl.sq_sel  = sq_sel_r;
    ctl.sq_part = sq_part_r;
    ctl.busy    = (state_r != sbcc_pkg::ST_IDLE);
    case (state_r)
      sbcc_pkg::ST_MUL_BX: ctl.mop = sbcc_pkg::MOP_BX;
      sbcc_pkg::ST_MUL_BY: begin
        ctl.mop   = sbcc_pkg::MOP_BY;
        ctl.wr_hx = 1'b1;
      end
      sbcc_pkg::ST_MUL_OX: begin
        ctl.mop   = sbcc_pkg::MOP_OX;
        ctl.wr_hy = 1'b1;
      end
      sbcc_pkg::ST_MUL_OY: begin
        ctl.mop   = sbcc_pkg::MOP_OY;
        ctl.wr_ox = 1'b1;
      end
      sbcc_pkg::ST_BB_X: begin
        ctl.wr_oy = 1'b1;
        ctl.bb_x  = 1'b1;
      end
      sbcc_pkg::ST_BB_Y: ctl.bb_y = 1'b1;
      sbcc_pkg::ST_GAP_X: begin
        ctl.wr_ox = 1'b1;
        ctl.gap_x = 1'b1;
      end
      sbcc_pkg::ST_GAP_Y: ctl.gap_y = 1'b1;
      sbcc_pkg::ST_SQ: begin
        ctl.mop      = sbcc_pkg::MOP_SQ;
        ctl.sq_issue = 1'b1;
      end
      sbcc_pkg::ST_DONE: ctl.done_ld = out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/sprite_box_circle_collision.sv
// Collision test of a stored reference sprite against a tested sprite. A load
// word (opcode 0) replaces the reference and gives no result; a test word
// (opcode 1) gives one result word with hit and test_kind. Each test runs on
// a single 24x24 multiplier shared under a small sequencer: box-box uses four
// half-extent products and two axis compares, box-circle uses three products,
// two clamp steps, then nine partial products that build r^2 - gx^2 - gy^2 in
// an 80-bit accumulator, and an unsupported pair skips them and gives no hit.
// The input is held off while a test runs; a finished result sits in the
// output register and a new word is accepted while it waits.
module sprite_box_circle_collision (
  input  logic              clk,
  input  logic              rst_n,
  sbcc_in_if.sink           in_ch,
  sbcc_out_if.source        out_ch
);

  function automatic logic [sbcc_pkg::POS_W-1:0] abs_pos(
    input logic signed [sbcc_pkg::POS_W-1:0] v
  );
    return v[sbcc_pkg::POS_W-1] ? sbcc_pkg::POS_W'(-v) : v;
  endfunction

  function automatic logic [sbcc_pkg::SCL_W-1:0] abs_scl(
    input logic signed [sbcc_pkg::SCL_W-1:0] v
  );
    return v[sbcc_pkg::SCL_W-1] ? sbcc_pkg::SCL_W'(-v) : v;
  endfunction

  sbcc_pkg::ctl_t ctl;
  logic           in_fire;
  logic           start;
  logic           out_free;

  // reference sprite
  logic                              ref_shape_r;
  logic signed [sbcc_pkg::POS_W-1:0] ref_px_r, ref_py_r, ref_ox_r, ref_oy_r;
  logic signed [sbcc_pkg::POS_W-1:0] ref_w_r, ref_h_r;
  logic signed [sbcc_pkg::SCL_W-1:0] ref_sx_r, ref_sy_r;

  // decode
  sbcc_pkg::kind_t                   kind_dec;
  logic                              t_true, r_true, swap;
  logic signed [sbcc_pkg::POS_W:0]   dp_x, dp_y, do_x, do_y;
  logic signed [sbcc_pkg::DD_W-1:0]  dd_x, dd_y;

  // operand latches
  sbcc_pkg::kind_t                   kind_r;
  logic [sbcc_pkg::POS_W-1:0]        bw_r, bh_r, ow_r, oh_r;
  logic [sbcc_pkg::SCL_W-1:0]        bsx_r, bsy_r, osx_r, osy_r;
  logic [sbcc_pkg::DMAG_W-1:0]       dxm_r, dym_r;

  // shared unit
  logic [sbcc_pkg::MUL_W-1:0]        mul_a, mul_b;
  logic [sbcc_pkg::PROD_W-1:0]       prod;
  logic [sbcc_pkg::HALF_W-1:0]       sq_val;
  logic [sbcc_pkg::HALF_SPLIT-1:0]   sq_hi, sq_lo;

  // intermediates
  logic [sbcc_pkg::HALF_W-1:0]       hx_r, hy_r, ox_r, oy_r, gx_r, gy_r;
  logic [sbcc_pkg::CMP_W-1:0]        dx_sc, dy_sc, gx_diff, gy_diff;
  logic                              xok_r, yok_r;
  logic [sbcc_pkg::ACC_W-1:0]        acc_r, acc_term;
  logic                              acc_en_r, acc_sub_r;
  sbcc_pkg::sq_part_t                acc_part_r;

  // output register
  logic                              out_valid_r, out_hit_r;
  sbcc_pkg::kind_t                   out_kind_r;
  logic                              hit_val;

  assign in_ch.ready = ~ctl.busy;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign start       = in_fire & (in_ch.opcode == sbcc_pkg::OP_TEST);
  assign out_free    = ~out_valid_r | out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_shape_r <= sbcc_pkg::SHP_RECT;
      ref_px_r    <= '0;
      ref_py_r    <= '0;
      ref_ox_r    <= '0;
      ref_oy_r    <= '0;
      ref_w_r     <= '0;
      ref_h_r     <= '0;
      ref_sx_r    <= '0;
      ref_sy_r    <= '0;
    end else if (in_fire && in_ch.opcode == sbcc_pkg::OP_LOAD) begin
      ref_shape_r <= in_ch.shape;
      ref_px_r    <= in_ch.pos_x;
      ref_py_r    <= in_ch.pos_y;
      ref_ox_r    <= in_ch.offset_x;
      ref_oy_r    <= in_ch.offset_y;
      ref_w_r     <= in_ch.coll_width;
      ref_h_r     <= in_ch.coll_height;
      ref_sx_r    <= in_ch.scale_x;
      ref_sy_r    <= in_ch.scale_y;
    end
  end

  assign t_true = (in_ch.coll_width == in_ch.coll_height) && (in_ch.scale_x == in_ch.scale_y);
  assign r_true = (ref_w_r == ref_h_r) && (ref_sx_r == ref_sy_r);

  always_comb begin
    kind_dec = sbcc_pkg::KIND_NONE;
    if (ref_shape_r == sbcc_pkg::SHP_RECT && in_ch.shape == sbcc_pkg::SHP_RECT) begin
      kind_dec = sbcc_pkg::KIND_BB;
    end else if (ref_shape_r == sbcc_pkg::SHP_RECT && t_true) begin
      kind_dec = sbcc_pkg::KIND_BC;
    end else if (in_ch.shape == sbcc_pkg::SHP_RECT && r_true) begin
      kind_dec = sbcc_pkg::KIND_BC;
    end
  end

  assign swap = (kind_dec == sbcc_pkg::KIND_BC) && (ref_shape_r == sbcc_pkg::SHP_ROUND);

  // box-box: 2*(dp+do), box-circle: 2*dp+do, both in 2^-9 units
  assign dp_x = (sbcc_pkg::POS_W+1)'(in_ch.pos_x) - (sbcc_pkg::POS_W+1)'(ref_px_r);
  assign dp_y = (sbcc_pkg::POS_W+1)'(in_ch.pos_y) - (sbcc_pkg::POS_W+1)'(ref_py_r);
  assign do_x = (sbcc_pkg::POS_W+1)'(in_ch.offset_x) - (sbcc_pkg::POS_W+1)'(ref_ox_r);
  assign do_y = (sbcc_pkg::POS_W+1)'(in_ch.offset_y) - (sbcc_pkg::POS_W+1)'(ref_oy_r);
  assign dd_x = (sbcc_pkg::DD_W'(dp_x) <<< 1) + ((kind_dec == sbcc_pkg::KIND_BB) ?
                (sbcc_pkg::DD_W'(do_x) <<< 1) : sbcc_pkg::DD_W'(do_x));
  assign dd_y = (sbcc_pkg::DD_W'(dp_y) <<< 1) + ((kind_dec == sbcc_pkg::KIND_BB) ?
                (sbcc_pkg::DD_W'(do_y) <<< 1) : sbcc_pkg::DD_W'(do_y));

  always_ff @(posedge clk) begin
    if (start) begin
      kind_r <= kind_dec;
      bw_r   <= swap ? abs_pos(in_ch.coll_width)  : abs_pos(ref_w_r);
      bh_r   <= swap ? abs_pos(in_ch.coll_height) : abs_pos(ref_h_r);
      bsx_r  <= swap ? abs_scl(in_ch.scale_x)     : abs_scl(ref_sx_r);
      bsy_r  <= swap ? abs_scl(in_ch.scale_y)     : abs_scl(ref_sy_r);
      ow_r   <= swap ? abs_pos(ref_w_r)  : abs_pos(in_ch.coll_width);
      oh_r   <= swap ? abs_pos(ref_h_r)  : abs_pos(in_ch.coll_height);
      osx_r  <= swap ? abs_scl(ref_sx_r) : abs_scl(in_ch.scale_x);
      osy_r  <= swap ? abs_scl(ref_sy_r) : abs_scl(in_ch.scale_y);
      dxm_r  <= dd_x[sbcc_pkg::DD_W-1] ? sbcc_pkg::DMAG_W'(-dd_x) : dd_x[sbcc_pkg::DMAG_W-1:0];
      dym_r  <= dd_y[sbcc_pkg::DD_W-1] ? sbcc_pkg::DMAG_W'(-dd_y) : dd_y[sbcc_pkg::DMAG_W-1:0];
    end
  end

  always_comb begin
    case (ctl.sq_sel)
      sbcc_pkg::SQ_RAD:  sq_val = ox_r;
      sbcc_pkg::SQ_GAPX: sq_val = gx_r;
      default:           sq_val = gy_r;
    endcase
  end

  assign sq_hi = sq_val[sbcc_pkg::HALF_W-1:sbcc_pkg::HALF_SPLIT];
  assign sq_lo = sq_val[sbcc_pkg::HALF_SPLIT-1:0];

  always_comb begin
    case (ctl.mop)
      sbcc_pkg::MOP_BX: begin
        mul_a = bw_r;
        mul_b = sbcc_pkg::MUL_W'(bsx_r);
      end
      sbcc_pkg::MOP_BY: begin
        mul_a = bh_r;
        mul_b = sbcc_pkg::MUL_W'(bsy_r);
      end
      sbcc_pkg::MOP_OX: begin
        mul_a = ow_r;
        mul_b = sbcc_pkg::MUL_W'(osx_r);
      end
      sbcc_pkg::MOP_OY: begin
        mul_a = oh_r;
        mul_b = sbcc_pkg::MUL_W'(osy_r);
      end
      default: begin
        case (ctl.sq_part)
          sbcc_pkg::PART_HH: begin
            mul_a = sbcc_pkg::MUL_W'(sq_hi);
            mul_b = sbcc_pkg::MUL_W'(sq_hi);
          end
          sbcc_pkg::PART_HL: begin
            mul_a = sbcc_pkg::MUL_W'(sq_hi);
            mul_b = sbcc_pkg::MUL_W'(sq_lo);
          end
          default: begin
            mul_a = sbcc_pkg::MUL_W'(sq_lo);
            mul_b = sbcc_pkg::MUL_W'(sq_lo);
          end
        endcase
      end
    endcase
  end

  sbcc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  sbcc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .kind     (kind_r),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // centre distance in 2^-17 units
  assign dx_sc   = sbcc_pkg::CMP_W'(dxm_r) << sbcc_pkg::FRAC_SH;
  assign dy_sc   = sbcc_pkg::CMP_W'(dym_r) << sbcc_pkg::FRAC_SH;
  assign gx_diff = dx_sc - sbcc_pkg::CMP_W'(hx_r);
  assign gy_diff = dy_sc - sbcc_pkg::CMP_W'(hy_r);

  always_ff @(posedge clk) begin
    if (ctl.wr_hx) hx_r <= prod[sbcc_pkg::HALF_W-1:0];
    if (ctl.wr_hy) hy_r <= prod[sbcc_pkg::HALF_W-1:0];
    if (ctl.wr_ox) ox_r <= prod[sbcc_pkg::HALF_W-1:0];
    if (ctl.wr_oy) oy_r <= prod[sbcc_pkg::HALF_W-1:0];
    if (ctl.bb_x)  xok_r <= dx_sc <= (sbcc_pkg::CMP_W'(hx_r) + sbcc_pkg::CMP_W'(ox_r));
    if (ctl.bb_y)  yok_r <= dy_sc <= (sbcc_pkg::CMP_W'(hy_r) + sbcc_pkg::CMP_W'(oy_r));
    if (ctl.gap_x) gx_r <= gx_diff[sbcc_pkg::CMP_W-1] ? '0 : gx_diff[sbcc_pkg::HALF_W-1:0];
    if (ctl.gap_y) gy_r <= gy_diff[sbcc_pkg::CMP_W-1] ? '0 : gy_diff[sbcc_pkg::HALF_W-1:0];
  end

  // acc = r^2 - gx^2 - gy^2, one partial product per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= ctl.sq_issue;
    end
  end

  always_ff @(posedge clk) begin
    acc_sub_r  <= (ctl.sq_sel != sbcc_pkg::SQ_RAD);
    acc_part_r <= ctl.sq_part;
  end

  always_comb begin
    case (acc_part_r)
      sbcc_pkg::PART_HH: acc_term = sbcc_pkg::ACC_W'(prod) << sbcc_pkg::SH_HH;
      sbcc_pkg::PART_HL: acc_term = sbcc_pkg::ACC_W'(prod) << sbcc_pkg::SH_HL;
      default:           acc_term = sbcc_pkg::ACC_W'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
    end else if (acc_en_r) begin
      acc_r <= acc_sub_r ? (acc_r - acc_term) : (acc_r + acc_term);
    end
  end

  always_comb begin
    case (kind_r)
      sbcc_pkg::KIND_BB: hit_val = xok_r & yok_r;
      sbcc_pkg::KIND_BC: hit_val = ~acc_r[sbcc_pkg::ACC_W-1] & (acc_r != '0);
      default:           hit_val = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.done_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done_ld) begin
      out_hit_r  <= hit_val;
      out_kind_r <= kind_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.test_kind = out_kind_r;

endmodule

### rtl/core/sbcc_chk.sv
module sbcc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_hit,
  input logic [1:0] out_kind
);

  // stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a load word never makes a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == sbcc_pkg::OP_LOAD && !out_valid |=> !out_valid)
    else $error("result after load word");

  // a test word occupies the unit
  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == sbcc_pkg::OP_TEST |=> !in_ready)
    else $error("input taken during test");

  // a hit only comes from a supported pair
  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_kind == sbcc_pkg::KIND_BB || out_kind == sbcc_pkg::KIND_BC))
    else $error("hit with unsupported pair");

endmodule

bind sprite_box_circle_collision sbcc_chk u_sbcc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit),
  .out_kind  (out_ch.test_kind)
);
